// ===== rtl/aod_pkg.sv =====
// ----------------------------------------------------------------------------
// aod_pkg: shared definitions for the audio onset detector
// Register indexes, fixed field widths, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package aod_pkg;

  // Parameter defaults
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_BLOCK_DEF   = 4096;
  localparam int COEFF_BITS_DEF  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 42;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROSSING_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_RISE_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_LIMIT  = 3'd6;

  // Fixed field widths
  localparam int BLOCK_LEN_W = 13;
  localparam int CROSS_LIM_W = 13;
  localparam int ENERGY_W    = 42;
  localparam int RISE_W      = 16;
  localparam int COOL_W      = 8;
  localparam int CROSS_W     = 12;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [CROSS_W-1:0]  CROSS_MAX  = '1;

  // Register reset values
  localparam logic [BLOCK_LEN_W-1:0] BLOCK_LENGTH_RST    = 13'd512;
  localparam int                     ATTACK_COEFF_RST    = 47;
  localparam int                     RELEASE_COEFF_RST   = 5;
  localparam logic [CROSS_LIM_W-1:0] CROSSING_LIMIT_RST  = 13'd41;
  localparam logic [ENERGY_W-1:0]    ENERGY_LIMIT_RST    = 42'd2199;
  localparam logic [RISE_W-1:0]      PEAK_RISE_LIMIT_RST = 16'd13;
  localparam logic [COOL_W-1:0]      COOLDOWN_LIMIT_RST  = 8'd10;

endpackage

// ===== rtl/audio_onset_detector_core.sv =====
// ----------------------------------------------------------------------------
// audio_onset_detector_core: block-based onset detector for audio samples
// Peak envelope, per-block crossing count, energy and onset trigger logic.
// ----------------------------------------------------------------------------
// Takes one signed sample per request and emits one result at the end of each
// block of block_length samples (zero means 1, longer than MAX_BLOCK means
// MAX_BLOCK). A sample is taken every cycle unless a block-end sample is held:
// it waits in the input register, its envelope multiply-add and block
// statistics are applied as it leaves that register, and a block-end result is
// loaded into the output register at that same edge. Samples that end no block
// keep flowing while a result waits; a block-end sample waits only while the
// previous result is still untaken. The per-sample envelope multiply-add with
// its compare against the block peak is the path that sets this rate. The user
// must write configuration only while the block is idle; it is not enforced.
module audio_onset_detector_core
  import aod_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int COEFF_BITS  = COEFF_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  // samples
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  // results
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_onset,
  output logic                         out_armed_off,
  output logic [SAMPLE_BITS-1:0]       out_block_peak,
  output logic [CROSS_W-1:0]           out_crossing_count
);

  localparam int LW   = $clog2(MAX_BLOCK + 1);
  localparam int IW   = $clog2(MAX_BLOCK);
  localparam int CMPW = (LW > BLOCK_LEN_W) ? LW : BLOCK_LEN_W;
  localparam int SQW  = 2 * SAMPLE_BITS;
  localparam int AW   = ((SQW > ENERGY_W) ? SQW : ENERGY_W) + 1;
  localparam int RW   = (SAMPLE_BITS > RISE_W) ? SAMPLE_BITS : RISE_W;
  localparam int PW   = SAMPLE_BITS + COEFF_BITS;
  localparam logic [SAMPLE_BITS-1:0] ENV_MAX = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  // Configuration registers
  logic [BLOCK_LEN_W-1:0] cfg_block_len_r;
  logic [COEFF_BITS-1:0]  cfg_attack_r;
  logic [COEFF_BITS-1:0]  cfg_release_r;
  logic [CROSS_LIM_W-1:0] cfg_cross_lim_r;
  logic [ENERGY_W-1:0]    cfg_energy_lim_r;
  logic [RISE_W-1:0]      cfg_rise_lim_r;
  logic [COOL_W-1:0]      cfg_cool_lim_r;

  // Detector state
  logic [SAMPLE_BITS-1:0] env_r, env_nxt;
  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic [SAMPLE_BITS-1:0] prev_peak_r;
  logic                   prev_sign_r;
  logic [CROSS_W-1:0]     cross_r, cross_nxt;
  logic [ENERGY_W-1:0]    energy_r, energy_nxt;
  logic [IW-1:0]          idx_r;
  logic                   latched_r, latched_nxt;
  logic [COOL_W-1:0]      cool_r, cool_nxt;
  logic                   hold_r, hold_nxt;

  // Pipeline registers
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   out_valid_r;
  logic                   out_onset_r;
  logic                   out_armed_r;
  logic [SAMPLE_BITS-1:0] out_peak_r;
  logic [CROSS_W-1:0]     out_cross_r;

  // Combinational work signals
  logic                   neg;
  logic [SAMPLE_BITS-1:0] mag;
  logic                   decay;
  logic [SAMPLE_BITS-1:0] mul_a;
  logic [COEFF_BITS-1:0]  mul_c;
  logic [PW-1:0]          prod;
  logic [SAMPLE_BITS-1:0] step;
  logic [SQW-1:0]         sq;
  logic [AW-1:0]          energy_sum;
  logic [CMPW-1:0]        len_eff;
  logic [CMPW-1:0]        idx_inc;
  logic                   blk_end;
  logic [SAMPLE_BITS-1:0] rise;
  logic                   cond;
  logic                   s1_go;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_block_len_r  <= BLOCK_LENGTH_RST;
      cfg_attack_r     <= COEFF_BITS'(ATTACK_COEFF_RST);
      cfg_release_r    <= COEFF_BITS'(RELEASE_COEFF_RST);
      cfg_cross_lim_r  <= CROSSING_LIMIT_RST;
      cfg_energy_lim_r <= ENERGY_LIMIT_RST;
      cfg_rise_lim_r   <= PEAK_RISE_LIMIT_RST;
      cfg_cool_lim_r   <= COOLDOWN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_LENGTH:    cfg_block_len_r  <= cfg_wdata[BLOCK_LEN_W-1:0];
        REG_ATTACK_COEFF:    cfg_attack_r     <= cfg_wdata[COEFF_BITS-1:0];
        REG_RELEASE_COEFF:   cfg_release_r    <= cfg_wdata[COEFF_BITS-1:0];
        REG_CROSSING_LIMIT:  cfg_cross_lim_r  <= cfg_wdata[CROSS_LIM_W-1:0];
        REG_ENERGY_LIMIT:    cfg_energy_lim_r <= cfg_wdata[ENERGY_W-1:0];
        REG_PEAK_RISE_LIMIT: cfg_rise_lim_r   <= cfg_wdata[RISE_W-1:0];
        REG_COOLDOWN_LIMIT:  cfg_cool_lim_r   <= cfg_wdata[COOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-sample arithmetic: magnitude, envelope step, square, block end
  always_comb begin
    neg     = s1_sample_r[SAMPLE_BITS-1];
    mag     = neg ? (~s1_sample_r + SAMPLE_BITS'(1)) : s1_sample_r;
    decay   = env_r > mag;
    // share one multiplier between the attack and release branches
    mul_a   = decay ? env_r : (mag - env_r);
    mul_c   = decay ? cfg_release_r : cfg_attack_r;
    prod    = PW'(mul_a) * PW'(mul_c);
    step    = prod[PW-1:COEFF_BITS];
    env_nxt = decay ? (env_r - step) : (env_r + step);
    peak_nxt = (env_nxt > peak_r) ? env_nxt : peak_r;

    sq         = SQW'(mag) * SQW'(mag);
    energy_sum = AW'(energy_r) + AW'(sq);
    energy_nxt = (energy_sum > AW'(ENERGY_MAX)) ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];

    cross_nxt = cross_r;
    if (idx_r != '0 && neg != prev_sign_r && cross_r != CROSS_MAX) begin
      cross_nxt = cross_r + CROSS_W'(1);
    end

    len_eff = CMPW'(cfg_block_len_r);
    if (len_eff == '0) begin
      len_eff = CMPW'(1);
    end else if (len_eff > CMPW'(MAX_BLOCK)) begin
      len_eff = CMPW'(MAX_BLOCK);
    end
    idx_inc = CMPW'(idx_r) + CMPW'(1);
    blk_end = idx_inc >= len_eff;
  end

  // Onset decision and cooldown at block end
  always_comb begin
    rise = peak_nxt - prev_peak_r;
    cond = ({1'b0, cross_nxt} < cfg_cross_lim_r) && (energy_nxt > cfg_energy_lim_r) &&
           (peak_nxt > prev_peak_r) && (RW'(rise) > RW'(cfg_rise_lim_r));
    latched_nxt = latched_r;
    cool_nxt    = cool_r;
    hold_nxt    = hold_r;
    if (cond) begin
      if (!latched_r) begin
        hold_nxt    = 1'b1;
        latched_nxt = 1'b1;
      end
    end else begin
      if (latched_r) begin
        if (cool_r < cfg_cool_lim_r) begin
          cool_nxt = cool_r + COOL_W'(1);
        end else begin
          cool_nxt    = '0;
          latched_nxt = 1'b0;
        end
      end
      hold_nxt = 1'b0;
    end
  end

  // Advance the input register unless a block-end result would overrun the output
  assign s1_go    = s1_valid_r && (!blk_end || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  // Capture the incoming request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample;
    end
  end

  // Update detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r       <= '0;
      peak_r      <= '0;
      prev_peak_r <= '0;
      prev_sign_r <= 1'b0;
      cross_r     <= '0;
      energy_r    <= '0;
      idx_r       <= '0;
      latched_r   <= 1'b0;
      cool_r      <= '0;
      hold_r      <= 1'b0;
    end else if (s1_go) begin
      env_r       <= env_nxt;
      prev_sign_r <= neg;
      if (blk_end) begin
        prev_peak_r <= peak_nxt;
        peak_r      <= '0;
        cross_r     <= '0;
        energy_r    <= '0;
        idx_r       <= '0;
        latched_r   <= latched_nxt;
        cool_r      <= cool_nxt;
        hold_r      <= hold_nxt;
      end else begin
        peak_r   <= peak_nxt;
        cross_r  <= cross_nxt;
        energy_r <= energy_nxt;
        idx_r    <= idx_inc[IW-1:0];
      end
    end
  end

  // Hold or drop the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && blk_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && blk_end) begin
      out_onset_r <= hold_nxt;
      out_armed_r <= latched_nxt;
      out_peak_r  <= peak_nxt;
      out_cross_r <= cross_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_onset          = out_onset_r;
  assign out_armed_off      = out_armed_r;
  assign out_block_peak     = out_peak_r;
  assign out_crossing_count = out_cross_r;

`ifndef SYNTHESIS
  // Envelope stays within full-scale magnitude
  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= ENV_MAX)
    else $error("envelope above full scale");

  // Cooldown counter runs only while latched
  a_cool_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !latched_r |-> (cool_r == '0))
    else $error("cooldown count nonzero while unlatched");

  // A reported onset always comes with the trigger latched
  a_onset_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_onset_r) |-> out_armed_r)
    else $error("onset without latched trigger");

  // Block statistics restart after a result is produced
  a_blk_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && blk_end) |=> (idx_r == '0 && cross_r == '0 && energy_r == '0))
    else $error("block state not cleared at block end");

  // Crossings never outnumber the samples seen in the block
  a_cross_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CMPW + CROSS_W)'(cross_r) <= (CMPW + CROSS_W)'(idx_r))
    else $error("crossing count exceeds sample index");
`endif

endmodule

// ===== bench/onset_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// onset_checker: result predictor and comparator for the onset detector
// Watches the sample, result and register ports, runs its own copy of the
// envelope, block statistics and trigger, and compares every block result.
// ----------------------------------------------------------------------------
module onset_checker
  import aod_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic signed [15:0]    in_sample,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_onset,
  input  logic                  out_armed_off,
  input  logic [15:0]           out_block_peak,
  input  logic [CROSS_W-1:0]    out_crossing_count,
  output int                    fail_count = 0,
  output int                    pending = 0,
  output int                    block_count = 0,
  output int                    onset_count = 0
);

  typedef struct packed {
    logic               onset;
    logic               armed_off;
    logic [15:0]        peak;
    logic [CROSS_W-1:0] crossings;
  } block_result_t;

  block_result_t expected_blocks[$];

  // register copy
  logic [BLOCK_LEN_W-1:0] blk_len;
  logic [15:0]            attack_w;
  logic [15:0]            decay_w;
  logic [CROSS_LIM_W-1:0] cross_lim;
  logic [ENERGY_W-1:0]    energy_lim;
  logic [RISE_W-1:0]      rise_lim;
  logic [COOL_W-1:0]      cool_lim;

  // detector state
  logic [16:0]         env_q;
  logic [16:0]         peak_q;
  logic [16:0]         last_peak_q;
  logic                sign_q;
  logic [CROSS_W-1:0]  cross_q;
  logic [ENERGY_W-1:0] energy_q;
  int unsigned         pos_q;
  logic                latched_q;
  logic [COOL_W-1:0]   cool_q;
  logic                hold_q;

  int fails = 0;
  int blocks = 0;
  int onsets = 0;

  // Advance the detector by one sample; return 1 with the block result at a block end.
  function automatic bit detect_sample(input logic [15:0] s, output block_result_t r);
    logic        neg;
    logic [16:0] mag;
    logic [33:0] sq;
    logic [32:0] prod;
    logic [42:0] esum;
    int unsigned len;
    logic        fire;
    neg = s[15];
    mag = neg ? 17'h10000 - {1'b0, s} : {1'b0, s};
    sq  = mag * mag;
    len = (blk_len == '0) ? 1 :
          ((blk_len > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : int'(blk_len));

    // count a sign change only inside the block
    if (pos_q != 0 && neg != sign_q && cross_q < CROSS_MAX) cross_q++;
    sign_q = neg;

    // decay toward the sample when above it, else attack
    if (env_q > mag) begin
      prod  = env_q * decay_w;
      env_q = env_q - prod[32:16];
    end else begin
      prod  = (mag - env_q) * attack_w;
      env_q = env_q + prod[32:16];
    end
    if (env_q > peak_q) peak_q = env_q;

    // saturate the energy sum
    esum = energy_q + sq;
    energy_q = (esum > ENERGY_MAX) ? ENERGY_MAX : esum[ENERGY_W-1:0];

    if (pos_q + 1 < len) begin
      pos_q++;
      return 1'b0;
    end

    // block end: trigger decision and cooldown
    fire = cross_q < cross_lim && energy_q > energy_lim && peak_q > last_peak_q &&
           (peak_q - last_peak_q) > rise_lim;
    if (fire) begin
      if (!latched_q) begin
        hold_q    = 1'b1;
        latched_q = 1'b1;
      end
    end else begin
      if (latched_q) begin
        if (cool_q < cool_lim) begin
          cool_q++;
        end else begin
          cool_q    = '0;
          latched_q = 1'b0;
        end
      end
      hold_q = 1'b0;
    end

    r.onset     = hold_q;
    r.armed_off = latched_q;
    r.peak      = peak_q[15:0];
    r.crossings = cross_q;

    last_peak_q = peak_q;
    peak_q      = '0;
    cross_q     = '0;
    energy_q    = '0;
    pos_q       = 0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    block_result_t got;
    block_result_t want;
    if (!rst_n) begin
      blk_len     = BLOCK_LENGTH_RST;
      attack_w    = 16'(ATTACK_COEFF_RST);
      decay_w     = 16'(RELEASE_COEFF_RST);
      cross_lim   = CROSSING_LIMIT_RST;
      energy_lim  = ENERGY_LIMIT_RST;
      rise_lim    = PEAK_RISE_LIMIT_RST;
      cool_lim    = COOLDOWN_LIMIT_RST;
      env_q       = '0;
      peak_q      = '0;
      last_peak_q = '0;
      sign_q      = 1'b0;
      cross_q     = '0;
      energy_q    = '0;
      pos_q       = 0;
      latched_q   = 1'b0;
      cool_q      = '0;
      hold_q      = 1'b0;
      expected_blocks.delete();
    end else begin
      // compare a taken result against the oldest prediction
      if (out_valid && out_ready) begin
        got = '{out_onset, out_armed_off, out_block_peak, out_crossing_count};
        if (expected_blocks.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] unexpected result: onset %0b armed %0b peak %0d crossings %0d",
                     $realtime, got.onset, got.armed_off, got.peak, got.crossings);
        end else begin
          want = expected_blocks.pop_front();
          blocks++;
          if (got.onset) onsets++;
          if (got != want) begin
            fails++;
            if (fails <= 10)
              $display("[%0t] block %0d mismatch: expected onset %0b armed %0b peak %0d xc %0d, got onset %0b armed %0b peak %0d xc %0d",
                       $realtime, blocks, want.onset, want.armed_off, want.peak,
                       want.crossings, got.onset, got.armed_off, got.peak, got.crossings);
          end
        end
      end

      // predict from each accepted sample request
      if (in_valid && in_ready) begin
        if (detect_sample(in_sample, want)) expected_blocks.push_back(want);
      end

      // mirror register writes, drop unknown indexes
      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCK_LENGTH:    blk_len    = cfg_wdata[BLOCK_LEN_W-1:0];
          REG_ATTACK_COEFF:    attack_w   = cfg_wdata[15:0];
          REG_RELEASE_COEFF:   decay_w    = cfg_wdata[15:0];
          REG_CROSSING_LIMIT:  cross_lim  = cfg_wdata[CROSS_LIM_W-1:0];
          REG_ENERGY_LIMIT:    energy_lim = cfg_wdata[ENERGY_W-1:0];
          REG_PEAK_RISE_LIMIT: rise_lim   = cfg_wdata[RISE_W-1:0];
          REG_COOLDOWN_LIMIT:  cool_lim   = cfg_wdata[COOL_W-1:0];
          default: ;
        endcase
      end
    end
    pending     <= expected_blocks.size();
    fail_count  <= fails;
    block_count <= blocks;
    onset_count <= onsets;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the audio onset detector core
// Drives sample requests in bursts through a series of register settings,
// stalls the result side on its own pattern, and takes the verdict from the
// onset checker.
// ----------------------------------------------------------------------------
module tb_top;
  import aod_pkg::*;

  localparam int CLOCK_LIMIT    = 500000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int TAIL_CYCLES    = 8;
  localparam int RANDOM_PHASES  = 4;
  localparam int PHASE_SAMPLES  = 60;
  localparam int RESET_SAMPLES  = 180;
  localparam int SINGLE_SAMPLES = 150;
  localparam int SPAN_SAMPLES   = 100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef enum int {BLK_QUIET, BLK_LOUD, BLK_NOISE, BLK_EXTREME} block_kind_t;
  typedef enum int {STALL_NONE, STALL_COIN, STALL_LONG} stall_style_t;

  typedef struct {
    logic [41:0] len;
    logic [41:0] attack;
    logic [41:0] decay;
    logic [41:0] cross_lim;
    logic [41:0] energy_lim;
    logic [41:0] rise_lim;
    logic [41:0] cool_lim;
  } settings_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [15:0]    in_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_onset;
  logic                  out_armed_off;
  logic [15:0]           out_block_peak;
  logic [CROSS_W-1:0]    out_crossing_count;

  int fail_count;
  int pending;
  int block_count;
  int onset_count;

  int cycles = 0;
  int sent = 0;
  int burst_left = 0;
  int eff_len = 512;
  int config_count = 0;

  stall_style_t ready_style = STALL_NONE;
  int ready_run = 0;
  int style_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  audio_onset_detector_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_onset          (out_onset),
    .out_armed_off      (out_armed_off),
    .out_block_peak     (out_block_peak),
    .out_crossing_count (out_crossing_count)
  );

  onset_checker onset_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_onset          (out_onset),
    .out_armed_off      (out_armed_off),
    .out_block_peak     (out_block_peak),
    .out_crossing_count (out_crossing_count),
    .fail_count         (fail_count),
    .pending            (pending),
    .block_count        (block_count),
    .onset_count        (onset_count)
  );

  // Stall the result side: free-running stretches, coin flips, long holds
  always @(posedge clk) begin
    if (style_left == 0) begin
      ready_style <= stall_style_t'($urandom_range(0, 2));
      style_left  <= $urandom_range(50, 300);
    end else begin
      style_left <= style_left - 1;
    end
    if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else begin
      case (ready_style)
        STALL_NONE: begin
          out_ready <= 1'b1;
          ready_run <= $urandom_range(8, 40);
        end
        STALL_COIN: begin
          out_ready <= 1'($urandom_range(0, 1));
          ready_run <= 0;
        end
        default: begin
          out_ready <= ~out_ready;
          ready_run <= out_ready ? $urandom_range(1, 24) : $urandom_range(0, 3);
        end
      endcase
    end
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycles < CLOCK_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Hold a sample request until accepted, with random gaps between bursts
  task automatic push_sample(input logic [15:0] s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 64);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write one register, with junk above the register width
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [41:0] value,
                         input int width);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= (value & ((42'd1 << width) - 42'd1)) | (junk[41:0] << width);
    @(posedge clk);
  endtask

  // Write the full register set once the block has gone quiet
  task automatic apply_settings(input settings_t s);
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_put(REG_BLOCK_LENGTH,    s.len,        BLOCK_LEN_W);
    cfg_put(REG_ATTACK_COEFF,    s.attack,     16);
    cfg_put(REG_RELEASE_COEFF,   s.decay,      16);
    cfg_put(REG_CROSSING_LIMIT,  s.cross_lim,  CROSS_LIM_W);
    cfg_put(REG_ENERGY_LIMIT,    s.energy_lim, ENERGY_W);
    cfg_put(REG_PEAK_RISE_LIMIT, s.rise_lim,   RISE_W);
    cfg_put(REG_COOLDOWN_LIMIT,  s.cool_lim,   COOL_W);
    cfg_put(REG_SPARE,           42'({$urandom, $urandom}), CFG_DATA_W);
    cfg_we <= 1'b0;
    eff_len = (s.len[12:0] == '0) ? 1 :
              ((s.len[12:0] > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : int'(s.len[12:0]));
    config_count++;
  endtask

  function automatic logic [15:0] make_sample(input block_kind_t k, input logic neg);
    logic [15:0] v;
    case (k)
      BLK_QUIET: v = 16'($urandom_range(0, 128)) - 16'd64;
      BLK_LOUD: begin
        v = 16'($urandom_range(8192, 32767));
        if (neg) v = -v;
      end
      BLK_NOISE: v = 16'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 16'h0000;
          3:       v = 16'hFFFF;
          default: v = 16'h0001;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic block_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return BLK_QUIET;
    if (r < 70) return BLK_LOUD;
    if (r < 85) return BLK_NOISE;
    return BLK_EXTREME;
  endfunction

  // Fill one block with samples of a single kind; loud samples share one sign
  task automatic play_block(input block_kind_t k);
    logic neg;
    neg = 1'($urandom_range(0, 1));
    repeat (eff_len) push_sample(make_sample(k, neg));
  endtask

  initial begin : stimulus
    settings_t s;
    int i;
    int start;
    logic [15:0] corner_samples [22];

    corner_samples = '{
      16'h0000, 16'h7FFF, 16'h8000,  16'hFFFF, 16'h0000, 16'h0001,
      16'h7FFF, 16'h7FFF, 16'h7FFF,  16'h8000, 16'h8000, 16'h8000,
      16'h0000, 16'h0000, 16'h0000,  16'h0001, 16'hFFFF, 16'h0001,
      16'h8000, 16'h7FFF, 16'h8000,  16'h0064};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // registers at their reset values: part of a block, cut short by the next length
    repeat (RESET_SAMPLES) push_sample(make_sample(BLK_LOUD, 1'b0));

    // corner samples, full-scale weights, every limit wide open
    apply_settings('{len: 42'd3, attack: 42'd65535, decay: 42'd65535, cross_lim: 42'd4096,
                     energy_lim: 42'd0, rise_lim: 42'd0, cool_lim: 42'd0});
    foreach (corner_samples[i]) push_sample(corner_samples[i]);

    // shorten the block mid-way, then single-sample blocks with the longest cooldown
    apply_settings('{len: 42'd1, attack: 42'd65535, decay: 42'd2000, cross_lim: 42'd1,
                     energy_lim: 42'd0, rise_lim: 42'd0, cool_lim: 42'd255});
    repeat (SINGLE_SAMPLES) push_sample(make_sample(pick_kind(), 1'($urandom_range(0, 1))));

    // zero length and frozen envelope
    apply_settings('{len: 42'd0, attack: 42'd0, decay: 42'd0, cross_lim: 42'd2,
                     energy_lim: 42'd5, rise_lim: 42'd0, cool_lim: 42'd0});
    repeat (40) push_sample(make_sample(BLK_NOISE, 1'b0));

    // oversize length setting with full-scale negative samples
    apply_settings('{len: 42'd8191, attack: 42'd30000, decay: 42'd100, cross_lim: 42'd0,
                     energy_lim: ENERGY_MAX, rise_lim: 42'd100, cool_lim: 42'd3});
    repeat (SPAN_SAMPLES) push_sample(16'h8000);

    // longest length setting with a sign change on every sample
    apply_settings('{len: 42'(MAX_BLOCK_DEF), attack: 42'd20000, decay: 42'd3000,
                     cross_lim: 42'd4096, energy_lim: 42'd0, rise_lim: 42'd32768,
                     cool_lim: 42'd255});
    for (i = 0; i < SPAN_SAMPLES; i++) push_sample(i[0] ? 16'h8000 : 16'h7FFF);

    // random settings, mostly block-aligned shapes with some loose noise
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      s.len = ($urandom_range(0, 9) < 6) ? 42'($urandom_range(1, 8)) :
                                           42'($urandom_range(9, 48));
      case ($urandom_range(0, 2))
        0:       s.attack = 42'd65535;
        1:       s.attack = 42'($urandom_range(4096, 65535));
        default: s.attack = 42'($urandom_range(0, 2047));
      endcase
      s.decay = ($urandom_range(0, 2) == 0) ? 42'($urandom_range(0, 65535)) :
                                              42'($urandom_range(0, 4095));
      s.cross_lim = ($urandom_range(0, 3) == 0) ? 42'd4096 :
                    42'($urandom_range(0, int'(s.len) + 1));
      s.energy_lim = ($urandom_range(0, 3) == 0) ? 42'd0 :
                     42'($urandom_range(0, 1 << 24)) << $urandom_range(0, 8);
      s.rise_lim = 42'($urandom_range(0, 6000));
      s.cool_lim = ($urandom_range(0, 4) == 0) ? 42'($urandom_range(0, 255)) :
                                                 42'($urandom_range(0, 5));
      apply_settings(s);
      start = sent;
      while (sent - start < PHASE_SAMPLES) begin
        if ($urandom_range(0, 99) < 85) play_block(pick_kind());
        else push_sample(make_sample(BLK_NOISE, 1'b0));
        if ($urandom_range(0, 19) == 0) settle();
      end
    end

    // drain and let the pipeline empty
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d samples under %0d register settings, lengths 0 through 8191.",
             sent, config_count);
    $display("Checked %0d block results, %0d with onset raised.", block_count, onset_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== audio_onset_detector_core.f =====
rtl/aod_pkg.sv
rtl/audio_onset_detector_core.sv
bench/onset_checker.sv
bench/tb_top.sv
